// File: sv/conv3_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tap arithmetic for the 3x3 rgb convolution
package conv3_pkg;

  localparam int DEFAULT_MAX_WIDTH = 2048;
  localparam int MIN_WIDTH         = 3;

  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int NROW       = 3;
  localparam int NCOL       = 3;
  localparam int NTAP       = NROW * NCOL;
  localparam int PIX_W      = NCH * CH_W;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int COEF_W     = 16;
  localparam int IMG_W_W    = 12;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = CH_W + 1 + COEF_W;

  // channel positions inside a pixel, red highest
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // row positions inside a window column
  localparam int ROW_TOP = 0;
  localparam int ROW_MID = 1;
  localparam int ROW_BOT = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAPS_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAPS_B   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP_LAST = 2'd3;

  localparam logic [IMG_W_W-1:0]    RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RST_COEF_TAPS_A   = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_COEF_TAPS_B   = 64'h0000_0001_0000_0000;
  localparam logic [COEF_W-1:0]     RST_COEF_TAP_LAST = 16'h0;

  localparam logic [1:0] ROWS_FULL = 2'd2;

  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;
  typedef pixel_t [NROW-1:0] column_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NROW-1:0] coef_col_t;
  typedef coef_t [NTAP-1:0] coef_all_t;

  typedef struct packed {
    logic shift;  // a new window column enters the chain
    logic step;   // pipeline advances
  } cell_ctrl_t;

  // low byte of (ch * coef) >> 8, truncated toward zero
  function automatic logic [CH_W-1:0] tap_byte(input logic [CH_W-1:0] ch,
                                               input logic signed [COEF_W-1:0] coef);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] q;
    p = $signed({1'b0, ch}) * coef;
    q = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    return q[2*CH_W-1:CH_W];
  endfunction

endpackage

// File: sv/conv3_line_mem.sv
`timescale 1ns / 1ps
// line store: one 48-bit entry per column, registered read with write forwarding
module conv3_line_mem #(
  parameter int DEPTH = conv3_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [conv3_pkg::LINE_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [conv3_pkg::LINE_W-1:0]  wr_data
);
  import conv3_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a word written in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/conv3_col_cell.sv
`timescale 1ns / 1ps
// window column cell: holds one window column and its tap bytes, adds them to psum
module conv3_col_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  conv3_pkg::cell_ctrl_t   ctrl,
  input  conv3_pkg::column_t      col_in,
  input  conv3_pkg::coef_col_t    coef,
  input  conv3_pkg::pixel_t       psum_in,
  output conv3_pkg::column_t      col_out,
  output conv3_pkg::pixel_t       psum_out
);
  import conv3_pkg::*;

  column_t col_r;
  column_t tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctrl.shift) begin
      col_r <= col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      for (int r = 0; r < NROW; r++) begin
        for (int c = 0; c < NCH; c++) begin
          tap_r[r][c] <= tap_byte(col_r[r][c], coef[r]);
        end
      end
    end
  end

  // sums wrap at 8 bits
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      psum_out[c] = psum_in[c];
      for (int r = 0; r < NROW; r++) begin
        psum_out[c] = psum_out[c] + tap_r[r][c];
      end
    end
  end

  assign col_out = col_r;

endmodule

// File: sv/rgb_conv3x3_stream.sv
`timescale 1ns / 1ps
// top level: streaming 3x3 rgb convolution with line store and window cell chain
//
// Takes one pixel per clock in raster order while in_stall is low and returns one
// pixel for every 3x3 window that lies inside the frame, anchored at its top-left
// corner. The word passes the stage 1, cell column, cell tap and output registers,
// and waits longer only while the output stalls. Each accepted pixel reads its
// column from the line store, and in the same clock the pixel before it writes its
// own column back. The store has one read port and one write port, with forwarding
// between them, and that column access sets the rate of one pixel per clock. Per
// channel the nine products (pixel times s7.8 coefficient, truncated toward zero)
// are summed and the low 8 bits returned; no alpha channel is carried. Image width
// is clamped to 3..MAX_WIDTH. The line store is not cleared after reset: the first
// two rows of a frame produce no output, so no stale entry reaches a result.
module rgb_conv3x3_stream #(
  parameter int MAX_WIDTH = conv3_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [conv3_pkg::CH_W-1:0]         in_red,
  input  logic [conv3_pkg::CH_W-1:0]         in_green,
  input  logic [conv3_pkg::CH_W-1:0]         in_blue,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [conv3_pkg::CH_W-1:0]         out_red,
  output logic [conv3_pkg::CH_W-1:0]         out_green,
  output logic [conv3_pkg::CH_W-1:0]         out_blue,
  output logic                               out_row_last,
  input  logic                               cfg_we,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [conv3_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import conv3_pkg::*;

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WMAXW = $clog2(MAX_WIDTH + 1);
  localparam int WW    = (WMAXW > IMG_W_W) ? WMAXW : IMG_W_W;

  // configuration registers
  logic [IMG_W_W-1:0]    image_width_r;
  logic [CFG_DATA_W-1:0] coef_a_r;
  logic [CFG_DATA_W-1:0] coef_b_r;
  logic [COEF_W-1:0]     coef_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= RST_IMAGE_WIDTH;
      coef_a_r      <= RST_COEF_TAPS_A;
      coef_b_r      <= RST_COEF_TAPS_B;
      coef_last_r   <= RST_COEF_TAP_LAST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width_r <= cfg_data[IMG_W_W-1:0];
        REG_COEF_TAPS_A:   coef_a_r      <= cfg_data;
        REG_COEF_TAPS_B:   coef_b_r      <= cfg_data;
        REG_COEF_TAP_LAST: coef_last_r   <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_raw;
  logic [WW-1:0] w_use;

  always_comb begin
    w_raw = WW'(image_width_r);
    if (w_raw < WW'(MIN_WIDTH)) begin
      w_use = WW'(MIN_WIDTH);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = w_raw;
    end
  end

  // pipeline control: everything moves while the skid register is empty
  logic adv;
  logic in_acc;
  logic skid_valid_r;

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  // position tracking
  logic [AW-1:0] column_count_r, column_count_nxt;
  logic [1:0]    rows_seen_r, rows_seen_nxt;
  logic [AW-1:0] cc0, col;
  logic [1:0]    rs0, rs1;
  logic [WW-1:0] col_inc;
  logic          emit, last;

  always_comb begin
    cc0 = in_frame_start ? '0 : column_count_r;
    rs0 = in_frame_start ? '0 : rows_seen_r;
    col = cc0;
    rs1 = rs0;
    // width shrunk below the current column: start a new row
    if (WW'(cc0) >= w_use) begin
      col = '0;
      rs1 = (rs0 == ROWS_FULL) ? ROWS_FULL : rs0 + 2'd1;
    end
    emit    = (WW'(col) >= WW'(2)) && (rs1 == ROWS_FULL);
    last    = (WW'(col) == (w_use - WW'(1)));
    col_inc = WW'(col) + WW'(1);
    if (col_inc >= w_use) begin
      column_count_nxt = '0;
      rows_seen_nxt    = (rs1 == ROWS_FULL) ? ROWS_FULL : rs1 + 2'd1;
    end else begin
      column_count_nxt = col_inc[AW-1:0];
      rows_seen_nxt    = rs1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      rows_seen_r    <= '0;
    end else if (in_acc) begin
      column_count_r <= column_count_nxt;
      rows_seen_r    <= rows_seen_nxt;
    end
  end

  // stage 1: line store data arrives
  logic          s1_valid_r, s1_emit_r, s1_last_r;
  pixel_t        s1_cur_r;
  logic [AW-1:0] s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_cur_r  <= {in_red, in_green, in_blue};
      s1_col_r  <= col;
    end
  end

  logic [LINE_W-1:0] line_rd;
  pixel_t            line_top, line_mid;
  logic              line_we;

  assign line_top = line_rd[LINE_W-1:PIX_W];
  assign line_mid = line_rd[PIX_W-1:0];
  assign line_we  = adv && s1_valid_r;

  conv3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (col),
    .rd_data (line_rd),
    .wr_en   (line_we),
    .wr_addr (s1_col_r),
    .wr_data ({line_mid, s1_cur_r})
  );

  // window cell chain: columns shift toward cell 0, partial sums toward the last cell
  cell_ctrl_t cell_ctrl;
  column_t    col_chain [NCOL:1];
  pixel_t     psum      [NCOL+1];
  coef_all_t  coef_all;

  assign cell_ctrl.shift = line_we;
  assign cell_ctrl.step  = adv;
  assign coef_all        = {coef_last_r, coef_b_r, coef_a_r};
  assign psum[0]         = '0;

  always_comb begin
    col_chain[NCOL][ROW_TOP] = line_top;
    col_chain[NCOL][ROW_MID] = line_mid;
    col_chain[NCOL][ROW_BOT] = s1_cur_r;
  end

  for (genvar c = 0; c < NCOL; c++) begin : g_cell
    coef_col_t cell_coef;
    for (genvar r = 0; r < NROW; r++) begin : g_coef
      assign cell_coef[r] = coef_all[r*NCOL + c];
    end
    if (c == 0) begin : g_first
      conv3_col_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .col_in   (col_chain[c+1]),
        .coef     (cell_coef),
        .psum_in  (psum[c]),
        .col_out  (),
        .psum_out (psum[c+1])
      );
    end else begin : g_rest
      conv3_col_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .col_in   (col_chain[c+1]),
        .coef     (cell_coef),
        .psum_in  (psum[c]),
        .col_out  (col_chain[c]),
        .psum_out (psum[c+1])
      );
    end
  end

  // stage 2: window in cells; stage 3: tap bytes in cells
  logic v2_r, last2_r, v3_r, last3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v2_r <= s1_valid_r && s1_emit_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last2_r <= s1_last_r;
      last3_r <= last2_r;
    end
  end

  // output register with skid
  logic   out_valid_r, take, push;
  pixel_t out_data_r, skid_data_r;
  logic   out_last_r, skid_last_r;

  assign take = out_valid_r && !out_stall;
  assign push = adv && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
        out_last_r <= skid_last_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_data_r <= psum[NCOL];
        out_last_r <= last3_r;
      end else begin
        skid_data_r <= psum[NCOL];
        skid_last_r <= last3_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_data_r[CH_RED];
  assign out_green    = out_data_r[CH_GREEN];
  assign out_blue     = out_data_r[CH_BLUE];
  assign out_row_last = out_last_r;

endmodule

// File: sim/tb_rgb_conv3x3_stream.sv
`timescale 1ns / 1ps
// testbench for rgb_conv3x3_stream: directed table, random frames, self-checking convolution
module tb_rgb_conv3x3_stream;
  import conv3_pkg::*;

  localparam int PIPE_LAT    = 4;
  localparam int RAND_ITEMS  = 2000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_W       = DEFAULT_MAX_WIDTH;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            row_last;
  } px_word_t;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_WORD} chk_t;
  typedef enum {ACT_CFG, ACT_PIXEL} act_t;
  typedef enum {STALL_NONE, STALL_RAND, STALL_HOLD} stall_mode_t;

  typedef struct {
    act_t                  act;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      rgb;
    logic                  fs;
    chk_t                  chk;
    px_word_t              word;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CH_W-1:0]       in_red = '0;
  logic [CH_W-1:0]       in_green = '0;
  logic [CH_W-1:0]       in_blue = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  out_row_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_conv3x3_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_row_last   (out_row_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of registers and pipeline state
  logic [IMG_W_W-1:0]    width_reg = RST_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] taps_lo   = RST_COEF_TAPS_A;
  logic [CFG_DATA_W-1:0] taps_hi   = RST_COEF_TAPS_B;
  logic [COEF_W-1:0]     tap_br    = RST_COEF_TAP_LAST;
  logic [LINE_W-1:0]     line_mem [MAX_W];
  logic [PIX_W-1:0]      win_reg [6];
  int                    col_pos = 0;
  int                    rows_done = 0;

  px_word_t    pending_px [$];
  px_word_t    want_px;
  stim_row_t   stim_tab [$];
  int          err_cnt = 0;
  int          burst_left = 0;
  int          rand_items = 0;
  int          cycle_cnt = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win_reg[i]) win_reg[i] = '0;
  end

  function automatic int clamp_width(int w);
    if (w < MIN_WIDTH) return MIN_WIDTH;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic logic signed [COEF_W-1:0] tap_coef(int k);
    if (k < 4) return taps_lo[COEF_W*k +: COEF_W];
    if (k < 8) return taps_hi[COEF_W*(k-4) +: COEF_W];
    return tap_br;
  endfunction

  // nine products truncated toward zero, summed, low byte kept
  function automatic logic [CH_W-1:0] chan_sum(input logic [NTAP-1:0][PIX_W-1:0] win,
                                               input int sh);
    int acc;
    int prod;
    int k;
    logic [CH_W-1:0] ch;
    acc = 0;
    for (k = 0; k < NTAP; k++) begin
      ch = win[k][sh +: CH_W];
      prod = int'(ch) * int'(tap_coef(k));
      acc += (prod < 0) ? -((-prod) >> 8) : (prod >> 8);
    end
    return acc[CH_W-1:0];
  endfunction

  task automatic convolve_pixel(input logic [PIX_W-1:0] cur, input logic fs,
                                output bit hit, output px_word_t res);
    int w;
    int col;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [NTAP-1:0][PIX_W-1:0] win;
    w = clamp_width(int'(width_reg));
    if (fs) begin
      col_pos = 0;
      rows_done = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      if (rows_done < int'(ROWS_FULL)) rows_done++;
    end
    col = col_pos;
    top = line_mem[col][LINE_W-1:PIX_W];
    mid = line_mem[col][PIX_W-1:0];
    hit = (col >= 2) && (rows_done >= int'(ROWS_FULL));
    res = '0;
    if (hit) begin
      win = {cur, win_reg[5], win_reg[4], mid, win_reg[3], win_reg[2],
             top, win_reg[1], win_reg[0]};
      res.red      = chan_sum(win, 2*CH_W);
      res.green    = chan_sum(win, CH_W);
      res.blue     = chan_sum(win, 0);
      res.row_last = (col == w - 1);
    end
    line_mem[col] = {mid, cur};
    win_reg[0] = win_reg[1];
    win_reg[2] = win_reg[3];
    win_reg[4] = win_reg[5];
    win_reg[1] = top;
    win_reg[3] = mid;
    win_reg[5] = cur;
    col++;
    if (col >= w) begin
      col = 0;
      if (rows_done < int'(ROWS_FULL)) rows_done++;
    end
    col_pos = col;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IMAGE_WIDTH:   width_reg = val[IMG_W_W-1:0];
      REG_COEF_TAPS_A:   taps_lo = val;
      REG_COEF_TAPS_B:   taps_hi = val;
      REG_COEF_TAP_LAST: tap_br = val[COEF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, let every expected word come out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] rgb, input logic fs, input chk_t chk,
                            input px_word_t typed);
    bit hit;
    px_word_t res;
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
    end
    in_valid       <= 1'b1;
    in_red         <= rgb[3*CH_W-1:2*CH_W];
    in_green       <= rgb[2*CH_W-1:CH_W];
    in_blue        <= rgb[CH_W-1:0];
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    burst_left--;
    convolve_pixel(rgb, fs, hit, res);
    case (chk)
      CHK_MODEL: if (hit) pending_px.push_back(res);
      CHK_WORD:  pending_px.push_back(typed);
      default: ;
    endcase
  endtask

  function automatic logic [COEF_W-1:0] pick_tap(int style);
    case (style)
      0: return COEF_W'($urandom);
      1: return COEF_W'(int'($urandom_range(0, 1024)) - 512);
      2: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      default: return ($urandom_range(0, 3) == 0) ? 16'h0100 : 16'h0000;
    endcase
  endfunction

  task automatic load_taps();
    int s;
    s = $urandom_range(0, 3);
    write_reg(REG_COEF_TAPS_A, {pick_tap(s), pick_tap(s), pick_tap(s), pick_tap(s)});
    write_reg(REG_COEF_TAPS_B, {pick_tap(s), pick_tap(s), pick_tap(s), pick_tap(s)});
    write_reg(REG_COEF_TAP_LAST, {48'd0, pick_tap(s)});
  endtask

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{act: ACT_CFG, idx: idx, data: val, rgb: '0, fs: 1'b0, chk: CHK_NONE, word: '0};
    return r;
  endfunction

  function automatic stim_row_t px_row(logic [PIX_W-1:0] rgb, logic fs, chk_t chk,
                                       px_word_t word);
    stim_row_t r;
    r = '{act: ACT_PIXEL, idx: '0, data: '0, rgb: rgb, fs: fs, chk: chk, word: word};
    return r;
  endfunction

  // receiver: free-running, random, or held stalls, mode changes now and then
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(10, 150);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_RAND: out_stall <= ($urandom_range(0, 2) == 0);
      default:    out_stall <= ((stall_left / 12) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        $error("unexpected word: red %02h green %02h blue %02h row_last %0b",
               out_red, out_green, out_blue, out_row_last);
        err_cnt++;
      end else begin
        want_px = pending_px.pop_front();
        if (out_red !== want_px.red) begin
          $error("out_red: expected %02h, got %02h", want_px.red, out_red);
          err_cnt++;
        end
        if (out_green !== want_px.green) begin
          $error("out_green: expected %02h, got %02h", want_px.green, out_green);
          err_cnt++;
        end
        if (out_blue !== want_px.blue) begin
          $error("out_blue: expected %02h, got %02h", want_px.blue, out_blue);
          err_cnt++;
        end
        if (out_row_last !== want_px.row_last) begin
          $error("out_row_last: expected %0b, got %0b", want_px.row_last, out_row_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[rgb_conv3x3_stream] ERROR");
    $finish;
  end

  initial begin
    int eff;
    int len;
    int ev;
    int nfr;
    bit fs_first;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no frame_start after reset, reset taps: only tap 6 set to 1/256, so all zero
    stim_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 64'd4));
    repeat (10) stim_tab.push_back(px_row(24'hFFFFFF, 1'b0, CHK_NONE, '0));
    stim_tab.push_back(px_row(24'hFFFFFF, 1'b0, CHK_WORD, {8'h00, 8'h00, 8'h00, 1'b0}));
    // shrink mid-row: column 3 of width 4 ends the row
    stim_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 64'd3));
    stim_tab.push_back(cfg_row(REG_COEF_TAPS_A, 64'h8000_8000_8000_8000));
    stim_tab.push_back(cfg_row(REG_COEF_TAPS_B, 64'h8000_8000_8000_8000));
    stim_tab.push_back(cfg_row(REG_COEF_TAP_LAST, 64'h8000));
    repeat (2) stim_tab.push_back(px_row(24'hFFFFFF, 1'b0, CHK_NONE, '0));
    stim_tab.push_back(px_row(24'hFFFFFF, 1'b0, CHK_WORD, {8'h80, 8'h80, 8'h80, 1'b1}));
    // width 0 acts as 3
    stim_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 64'd0));
    stim_tab.push_back(cfg_row(REG_COEF_TAPS_A, 64'h7FFF_7FFF_7FFF_7FFF));
    stim_tab.push_back(cfg_row(REG_COEF_TAPS_B, 64'h7FFF_7FFF_7FFF_7FFF));
    stim_tab.push_back(cfg_row(REG_COEF_TAP_LAST, 64'h7FFF));
    repeat (2) stim_tab.push_back(px_row(24'hFFFFFF, 1'b0, CHK_NONE, '0));
    stim_tab.push_back(px_row(24'hFFFFFF, 1'b0, CHK_WORD, {8'h77, 8'h77, 8'h77, 1'b1}));
    repeat (3) stim_tab.push_back(px_row(24'h000000, 1'b0, CHK_MODEL, '0));
    stim_tab.push_back(px_row(24'h5AA53C, 1'b1, CHK_NONE, '0));
    stim_tab.push_back(px_row(24'hC33C99, 1'b0, CHK_NONE, '0));

    foreach (stim_tab[i]) begin
      if (stim_tab[i].act == ACT_CFG) begin
        drain_results();
        write_reg(stim_tab[i].idx, stim_tab[i].data);
      end else begin
        send_pixel(stim_tab[i].rgb, stim_tab[i].fs, stim_tab[i].chk, stim_tab[i].word);
      end
    end

    // widest frame, width above the maximum clamps to it
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 64'd4095);
    load_taps();
    for (int i = 0; i < 2 * MAX_W + 3; i++)
      send_pixel({rand_chan(), rand_chan(), rand_chan()}, i == 0, CHK_MODEL, '0);

    while (rand_items < RAND_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: eff = $urandom_range(0, MIN_WIDTH - 1);
        1: eff = $urandom_range(13, 64);
        default: eff = $urandom_range(MIN_WIDTH, 12);
      endcase
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(eff));
      eff = clamp_width(eff);
      load_taps();
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        len = eff * $urandom_range(3, 5) + $urandom_range(0, eff - 1);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 3 * eff);
        // later frames sometimes run on without a frame_start
        fs_first = (f == 0) || ($urandom_range(0, 5) != 0);
        for (int i = 0; i < len; i++) begin
          ev = $urandom_range(0, 499);
          if (ev == 0) begin
            drain_results();
          end else if (ev == 1) begin
            drain_results();
            load_taps();
          end else if (ev == 2 && eff > MIN_WIDTH) begin
            // narrowing is safe mid-frame, widening is not
            drain_results();
            eff = $urandom_range(MIN_WIDTH, eff - 1);
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(eff));
          end
          send_pixel({rand_chan(), rand_chan(), rand_chan()},
                     (i == 0 && fs_first) || ($urandom_range(0, 199) == 0), CHK_MODEL, '0);
          rand_items++;
        end
      end
    end

    drain_results();
    repeat (4 * PIPE_LAT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[rgb_conv3x3_stream] OK");
    end else begin
      $display("[rgb_conv3x3_stream] ERROR");
    end
    $finish;
  end

endmodule
